### rtl/adsr_pkg.sv
// Shared constants for the ADSR envelope generator: default widths, mode,
// phase and register index codes, and reset values of the configuration registers.
// No dependencies.
`timescale 1ns / 1ps

package adsr_pkg;

    // default widths
    localparam int DEF_COUNT_BITS    = 20;
    localparam int DEF_AMP_FRAC_BITS = 15;
    localparam int DEF_AMP_W         = DEF_AMP_FRAC_BITS + 1;

    // item modes
    localparam logic [1:0] MODE_TICK     = 2'd0;
    localparam logic [1:0] MODE_NOTE_ON  = 2'd1;
    localparam logic [1:0] MODE_NOTE_OFF = 2'd2;

    // envelope phases
    localparam int PHASE_W = 3;
    localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
    localparam logic [PHASE_W-1:0] PH_ATTACK  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_DECAY   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_SUSTAIN = 3'd3;
    localparam logic [PHASE_W-1:0] PH_RELEASE = 3'd4;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SINGLE  = 3'd4;

    // reset values: ramp lengths in ticks, sustain as tenths of full scale
    localparam longint unsigned ATTACK_RESET  = 480;
    localparam longint unsigned DECAY_RESET   = 480;
    localparam longint unsigned RELEASE_RESET = 4800;
    localparam int              SUSTAIN_TENTHS = 7;

endpackage

### rtl/adsr_cmd_if.sv
// Command channel of the envelope generator: valid/ready with mode and velocity.
// Depends on adsr_pkg for the default width.
`timescale 1ns / 1ps

interface adsr_cmd_if
    import adsr_pkg::*;
#(
    parameter int AMP_W = DEF_AMP_W
);
    logic             valid;
    logic             ready;
    logic [1:0]       mode;
    logic [AMP_W-1:0] velocity;

    modport source (output valid, output mode, output velocity, input ready);
    modport sink   (input valid, input mode, input velocity, output ready);
endinterface

### rtl/adsr_env_if.sv
// Envelope result channel: valid/ready with amplitude and active flag.
// Depends on adsr_pkg for the default width.
`timescale 1ns / 1ps

interface adsr_env_if
    import adsr_pkg::*;
#(
    parameter int AMP_W = DEF_AMP_W
);
    logic             valid;
    logic             ready;
    logic [AMP_W-1:0] amplitude;
    logic             active;

    modport source (output valid, output amplitude, output active, input ready);
    modport sink   (input valid, input amplitude, input active, output ready);
endinterface

### rtl/adsr_envelope_generator_top.sv
// Top level of the linear ADSR envelope generator: phase sequencer, output
// register. Depends on adsr_pkg, adsr_cmd_if, adsr_env_if, adsr_cfg_regs, adsr_muldiv.
`timescale 1ns / 1ps

// Linear ADSR envelope in unsigned Q1.(AMP_FRAC_BITS). Every command beat
// (tick, note-on, note-off) returns exactly one result beat with the held or
// new level and the active flag. Note-on, note-off and ticks that end or hold
// a phase finish in the accept cycle: the result register is loaded at once
// and the next beat can be taken the following cycle. A tick inside an
// attack, decay or release ramp needs level*count/length; it runs through the
// shared multiply/divide unit, one registered multiply and then one quotient
// bit per cycle, and the next beat is taken only once the quotient is back
// and the result has entered the output register. The command channel is
// held off while that divide runs or while a finished result cannot enter the
// output register. Configuration writes are taken any cycle but are meant for
// idle periods; new lengths apply to the next tick. There is no clearing pass.
module adsr_envelope_generator_top
    import adsr_pkg::*;
#(
    parameter int COUNT_BITS    = DEF_COUNT_BITS,
    parameter int AMP_FRAC_BITS = DEF_AMP_FRAC_BITS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    adsr_cmd_if.sink                cmd,
    adsr_env_if.source              env,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_idx,
    input  logic [((COUNT_BITS > AMP_FRAC_BITS + 1) ? COUNT_BITS : AMP_FRAC_BITS + 1)-1:0]
                                    cfg_wdata
);
    localparam int AW    = AMP_FRAC_BITS + 1;
    localparam int CB    = COUNT_BITS;
    localparam int CFG_W = (CB > AW) ? CB : AW;
    localparam logic [AW-1:0] FULL = {1'b1, {AMP_FRAC_BITS{1'b0}}};

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0; // taking command beats
    localparam logic [1:0] ST_CALC = 2'd1; // ramp divide in flight
    localparam logic [1:0] ST_PUSH = 2'd2; // level ready, waiting for output slot

    // configuration
    logic [CB-1:0] attack_len;
    logic [CB-1:0] decay_len;
    logic [AW-1:0] sustain_raw;
    logic [CB-1:0] release_len;
    logic          single_shot;

    // envelope state
    logic [1:0]         st_reg,    st_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [CB-1:0]      cnt_reg,   cnt_next;
    logic [AW-1:0]      peak_reg,  peak_next;
    logic [AW-1:0]      level_reg, level_next;
    logic               pend_reg,  pend_next;

    // ramp step captured at accept: level = base +/- quotient
    logic [AW-1:0]      base_reg,  base_next;
    logic               sub_reg,   sub_next;

    // output register
    logic               ovalid_reg, ovalid_next;
    logic [AW-1:0]      oamp_reg,   oamp_next;
    logic               oact_reg,   oact_next;

    adsr_cfg_regs #(
        .COUNT_BITS    (COUNT_BITS),
        .AMP_FRAC_BITS (AMP_FRAC_BITS),
        .CFG_W         (CFG_W)
    ) u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .we          (cfg_we),
        .idx         (cfg_idx),
        .wdata       (cfg_wdata),
        .attack_len  (attack_len),
        .decay_len   (decay_len),
        .sustain_raw (sustain_raw),
        .release_len (release_len),
        .single_shot (single_shot)
    );

    // shared ramp unit
    logic          div_start;
    logic [AW-1:0] div_mcand;
    logic [CB-1:0] div_divisor;
    logic          div_busy;
    logic          div_done;
    logic [AW-1:0] div_quot;

    adsr_muldiv #(
        .AW (AW),
        .CB (CB)
    ) u_muldiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .mcand    (div_mcand),
        .count    (cnt_reg),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    logic          slot_free;
    logic          accept;
    logic          use_div;
    logic [AW-1:0] sus;
    logic [AW-1:0] vel_sat;
    logic          sus_ge_peak;

    assign sus         = (sustain_raw > FULL) ? FULL : sustain_raw;
    assign vel_sat     = (cmd.velocity > FULL) ? FULL : cmd.velocity;
    assign sus_ge_peak = (sus >= peak_reg);

    assign slot_free = !ovalid_reg || env.ready;
    assign cmd.ready = (st_reg == ST_IDLE) && slot_free;
    assign accept    = cmd.valid && cmd.ready;

    always_comb
    begin
        st_next     = st_reg;
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        peak_next   = peak_reg;
        level_next  = level_reg;
        pend_next   = pend_reg;
        base_next   = base_reg;
        sub_next    = sub_reg;
        ovalid_next = ovalid_reg && !env.ready;
        oamp_next   = oamp_reg;
        oact_next   = oact_reg;
        use_div     = 1'b0;
        div_start   = 1'b0;
        div_mcand   = '0;
        div_divisor = '0;

        unique case (st_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.mode)
                        MODE_TICK:
                        begin
                            unique case (phase_reg)
                                PH_ATTACK:
                                begin
                                    if (cnt_reg < attack_len)
                                    begin
                                        use_div     = 1'b1;
                                        div_mcand   = peak_reg;
                                        div_divisor = attack_len;
                                        base_next   = '0;
                                        sub_next    = 1'b0;
                                        cnt_next    = cnt_reg + CB'(1);
                                    end
                                    else
                                    begin
                                        level_next = peak_reg;
                                        phase_next = PH_DECAY;
                                        cnt_next   = '0;
                                    end
                                end
                                PH_DECAY:
                                begin
                                    if (cnt_reg < decay_len)
                                    begin
                                        // ramp toward sustain, either direction
                                        use_div     = 1'b1;
                                        div_mcand   = sus_ge_peak ? (sus - peak_reg)
                                                                  : (peak_reg - sus);
                                        div_divisor = decay_len;
                                        base_next   = peak_reg;
                                        sub_next    = !sus_ge_peak;
                                        cnt_next    = cnt_reg + CB'(1);
                                    end
                                    else
                                    begin
                                        level_next = sus;
                                        phase_next = PH_SUSTAIN;
                                        cnt_next   = '0;
                                    end
                                end
                                PH_SUSTAIN:
                                begin
                                    level_next = sus;
                                    if (pend_reg || single_shot)
                                    begin
                                        phase_next = PH_RELEASE;
                                        cnt_next   = '0;
                                    end
                                end
                                PH_RELEASE:
                                begin
                                    if (cnt_reg < release_len)
                                    begin
                                        use_div     = 1'b1;
                                        div_mcand   = sus;
                                        div_divisor = release_len;
                                        base_next   = sus;
                                        sub_next    = 1'b1;
                                        cnt_next    = cnt_reg + CB'(1);
                                    end
                                    else
                                    begin
                                        phase_next = PH_IDLE;
                                        level_next = '0;
                                    end
                                end
                                default:
                                begin
                                    phase_next = PH_IDLE;
                                    level_next = '0;
                                end
                            endcase
                        end
                        MODE_NOTE_ON:
                        begin
                            phase_next = PH_ATTACK;
                            cnt_next   = '0;
                            peak_next  = vel_sat;
                            pend_next  = 1'b0;
                        end
                        MODE_NOTE_OFF:
                        begin
                            pend_next = 1'b1;
                            if (phase_reg != PH_RELEASE)
                            begin
                                phase_next = PH_RELEASE;
                                cnt_next   = '0;
                            end
                        end
                        default: ; // unused mode, level held
                    endcase

                    if (use_div)
                    begin
                        div_start = 1'b1;
                        st_next   = ST_CALC;
                    end
                    else
                    begin
                        ovalid_next = 1'b1;
                        oamp_next   = level_next;
                        oact_next   = (phase_next != PH_IDLE);
                    end
                end
            end
            ST_CALC:
            begin
                if (div_done)
                begin
                    level_next = sub_reg ? (base_reg - div_quot) : (base_reg + div_quot);
                    st_next    = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    oamp_next   = level_reg;
                    oact_next   = (phase_reg != PH_IDLE);
                    st_next     = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= ST_IDLE;
            phase_reg  <= PH_IDLE;
            cnt_reg    <= '0;
            peak_reg   <= FULL;
            level_reg  <= '0;
            pend_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            st_reg     <= st_next;
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            peak_reg   <= peak_next;
            level_reg  <= level_next;
            pend_reg   <= pend_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        sub_reg  <= sub_next;
        oamp_reg <= oamp_next;
        oact_reg <= oact_next;
    end

    assign env.valid     = ovalid_reg;
    assign env.amplitude = oamp_reg;
    assign env.active    = oact_reg;

    // ramp unit only started when free
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("ramp unit started while busy");

    // a quotient only arrives while the sequencer waits for it
    a_done_calc: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (st_reg == ST_CALC))
        else $error("ramp result outside calc state");

    // pushed beat carries the computed level
    a_push_level: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_PUSH && slot_free) |=>
            (env.valid && env.amplitude == $past(level_reg)))
        else $error("pushed amplitude differs from level");

    // ramp result never exceeds full scale
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |=> (level_reg <= FULL))
        else $error("ramp level above full scale");
endmodule

### rtl/adsr_cfg_regs.sv
// Configuration register file: ramp lengths, sustain level and single-shot flag.
// Depends on adsr_pkg for register indexes and reset values.
`timescale 1ns / 1ps

module adsr_cfg_regs
    import adsr_pkg::*;
#(
    parameter int COUNT_BITS    = DEF_COUNT_BITS,
    parameter int AMP_FRAC_BITS = DEF_AMP_FRAC_BITS,
    parameter int CFG_W         = DEF_COUNT_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     we,
    input  logic [CFG_IDX_W-1:0]     idx,
    input  logic [CFG_W-1:0]         wdata,
    output logic [COUNT_BITS-1:0]    attack_len,
    output logic [COUNT_BITS-1:0]    decay_len,
    output logic [AMP_FRAC_BITS:0]   sustain_raw,
    output logic [COUNT_BITS-1:0]    release_len,
    output logic                     single_shot
);
    localparam int AW = AMP_FRAC_BITS + 1;
    localparam longint unsigned LEN_MAX = (64'd1 << COUNT_BITS) - 64'd1;
    localparam longint unsigned ATT_RST = (ATTACK_RESET > LEN_MAX) ? LEN_MAX : ATTACK_RESET;
    localparam longint unsigned DEC_RST = (DECAY_RESET > LEN_MAX) ? LEN_MAX : DECAY_RESET;
    localparam longint unsigned REL_RST = (RELEASE_RESET > LEN_MAX) ? LEN_MAX : RELEASE_RESET;
    // rounded fraction of full scale
    localparam longint unsigned SUS_RST =
        (SUSTAIN_TENTHS * (64'd1 << AMP_FRAC_BITS) + 64'd5) / 10;

    logic [COUNT_BITS-1:0] attack_reg,  attack_next;
    logic [COUNT_BITS-1:0] decay_reg,   decay_next;
    logic [AW-1:0]         sustain_reg, sustain_next;
    logic [COUNT_BITS-1:0] release_reg, release_next;
    logic                  single_reg,  single_next;

    always_comb
    begin
        attack_next  = attack_reg;
        decay_next   = decay_reg;
        sustain_next = sustain_reg;
        release_next = release_reg;
        single_next  = single_reg;
        if (we)
        begin
            unique case (idx)
                CFG_ATTACK:  attack_next  = wdata[COUNT_BITS-1:0];
                CFG_DECAY:   decay_next   = wdata[COUNT_BITS-1:0];
                CFG_SUSTAIN: sustain_next = wdata[AW-1:0];
                CFG_RELEASE: release_next = wdata[COUNT_BITS-1:0];
                CFG_SINGLE:  single_next  = wdata[0];
                default:     ; // unmapped index, write dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg  <= ATT_RST[COUNT_BITS-1:0];
            decay_reg   <= DEC_RST[COUNT_BITS-1:0];
            sustain_reg <= SUS_RST[AW-1:0];
            release_reg <= REL_RST[COUNT_BITS-1:0];
            single_reg  <= 1'b0;
        end
        else
        begin
            attack_reg  <= attack_next;
            decay_reg   <= decay_next;
            sustain_reg <= sustain_next;
            release_reg <= release_next;
            single_reg  <= single_next;
        end
    end

    assign attack_len  = attack_reg;
    assign decay_len   = decay_reg;
    assign sustain_raw = sustain_reg;
    assign release_len = release_reg;
    assign single_shot = single_reg;
endmodule

### rtl/adsr_muldiv.sv
// Shared ramp arithmetic: one registered multiply, then a serial restoring
// divide, one quotient bit per cycle. Depends on adsr_pkg for default widths.
`timescale 1ns / 1ps

module adsr_muldiv
    import adsr_pkg::*;
#(
    parameter int AW = DEF_AMP_W,
    parameter int CB = DEF_COUNT_BITS
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [AW-1:0] mcand,
    input  logic [CB-1:0] count,
    input  logic [CB-1:0] divisor,
    output logic          busy,
    output logic          done,
    output logic [AW-1:0] quotient
);
    // mcand*count/divisor, with count < divisor so the quotient fits AW bits
    localparam int PW     = AW + CB;
    localparam int STEP_W = $clog2(AW + 1);

    localparam logic [1:0] U_IDLE = 2'd0;
    localparam logic [1:0] U_MUL  = 2'd1;
    localparam logic [1:0] U_DIV  = 2'd2;

    logic [1:0]        st_reg,   st_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              done_reg, done_next;
    logic [AW-1:0]     a_reg,    a_next;
    logic [CB-1:0]     b_reg,    b_next;
    logic [CB-1:0]     d_reg,    d_next;
    logic [CB-1:0]     rem_reg,  rem_next;
    logic [AW-1:0]     q_reg,    q_next;

    logic [PW-1:0] prod;
    logic [CB:0]   trial;
    logic [CB:0]   diff;
    logic          ge;

    assign prod  = PW'(a_reg) * PW'(b_reg);
    assign trial = {rem_reg, q_reg[AW-1]};
    assign diff  = trial - {1'b0, d_reg};
    assign ge    = (trial >= {1'b0, d_reg});

    always_comb
    begin
        st_next   = st_reg;
        step_next = step_reg;
        done_next = 1'b0;
        a_next    = a_reg;
        b_next    = b_reg;
        d_next    = d_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        unique case (st_reg)
            U_IDLE:
            begin
                if (start)
                begin
                    a_next  = mcand;
                    b_next  = count;
                    d_next  = divisor;
                    st_next = U_MUL;
                end
            end
            U_MUL:
            begin
                // high part is below the divisor, low part shifts in bit by bit
                rem_next  = prod[PW-1:AW];
                q_next    = prod[AW-1:0];
                step_next = '0;
                st_next   = U_DIV;
            end
            U_DIV:
            begin
                rem_next  = ge ? diff[CB-1:0] : trial[CB-1:0];
                q_next    = {q_reg[AW-2:0], ge};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(AW - 1))
                begin
                    done_next = 1'b1;
                    st_next   = U_IDLE;
                end
            end
            default: st_next = U_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= U_IDLE;
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        d_reg   <= d_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign busy     = (st_reg != U_IDLE);
    assign done     = done_reg;
    assign quotient = q_reg;
endmodule
